FILE: hw/rtl/hrn_pkg.sv
// Shared widths, constants and register indexes for the heightmap range normaliser.
`timescale 1ns / 1ps
`default_nettype none

package hrn_pkg;

  // Field widths
  localparam int ELEV_W     = 32;
  localparam int ZS_W       = 24;
  localparam int Z_W        = 56;
  localparam int PIX_W      = 16;
  localparam int DS_W       = 8;
  localparam int ROW_LEN_W  = 13;
  localparam int NUM_W      = Z_W + PIX_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWNSCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 3'd4;

  // Default geometry
  localparam int MAX_ROW_LENGTH_DEF = 4096;

  // Output scales and flat-range handling
  localparam logic [PIX_W-1:0] SCALE_8     = 16'd255;
  localparam logic [PIX_W-1:0] SCALE_16    = 16'd65535;
  localparam logic [PIX_W-1:0] FLAT_MID_16 = 16'd32767;
  localparam int               SHIFT_8     = 8;
  localparam int               SHIFT_16    = 16;
  localparam int               FLAT_LIMIT  = 4;

  typedef logic signed [Z_W-1:0] z_t;

  localparam z_t Z_POS_LIMIT = {1'b0, {(Z_W-1){1'b1}}};
  localparam z_t Z_NEG_LIMIT = {1'b1, {(Z_W-1){1'b0}}};

  // Configuration reset values
  localparam logic [ZS_W-1:0]      Z_SCALE_RST   = 24'd65536;
  localparam logic [ELEV_W-1:0]    NODATA_RST    = 32'h8000_0000;
  localparam logic [DS_W-1:0]      DOWNSCALE_RST = 8'd1;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST   = 13'd4096;

endpackage

`default_nettype wire

FILE: hw/rtl/hrn_serial_mult.sv
// Bit-serial signed multiplier producing the negated scaled height z = -elevation * z_scale.
`timescale 1ns / 1ps
`default_nettype none

module hrn_serial_mult
  import hrn_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [ELEV_W-1:0] mcand,
  input  wire logic        [ZS_W-1:0]   mplier,
  output logic                          done,
  output z_t                            product
);

  localparam int CNT_W = $clog2(ZS_W);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [ZS_W-1:0]          mr_r;
  logic signed [ELEV_W-1:0] md_r;
  z_t                       acc_r;

  z_t   md_ext;
  z_t   term;
  z_t   acc_nxt;
  logic last;

  // One multiplier bit per cycle, MSB first; the sign bit adds, the others subtract
  always_comb begin
    md_ext  = {{(Z_W-ELEV_W){md_r[ELEV_W-1]}}, md_r};
    if (mr_r[ZS_W-1]) begin
      term = (cnt_r == '0) ? md_ext : -md_ext;
    end else begin
      term = '0;
    end
    acc_nxt = (acc_r <<< 1) + term;
    last    = (cnt_r == CNT_W'(ZS_W-1));
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mr_r  <= mplier;
      md_r  <= mcand;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mr_r  <= mr_r << 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hrn_serial_div.sv
// Restoring radix-2 divider with round-half-up on the final remainder.
`timescale 1ns / 1ps
`default_nettype none

module hrn_serial_div
  import hrn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [Z_W-1:0]   den,
  output logic                  done,
  output logic [PIX_W-1:0]      quot
);

  localparam int CNT_W = $clog2(PIX_W);

  logic             busy_r;
  logic             rnd_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [Z_W-1:0]   den_r;
  logic [Z_W:0]     rem_r;
  logic [PIX_W-1:0] nb_r;

  logic [Z_W:0] rem_sh;
  logic [Z_W:0] den_ext;
  logic         geq;
  logic [Z_W:0] rem_nxt;
  logic         round_up;
  logic         last;

  // One quotient bit per cycle; low numerator bits shift out as quotient bits shift in
  always_comb begin
    den_ext  = {1'b0, den_r};
    rem_sh   = {rem_r[Z_W-1:0], nb_r[PIX_W-1]};
    geq      = (rem_sh >= den_ext);
    rem_nxt  = geq ? (rem_sh - den_ext) : rem_sh;
    round_up = ({rem_r[Z_W-1:0], 1'b0} >= den_ext);
    last     = (cnt_r == CNT_W'(PIX_W-1));
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath; the remainder starts below the divisor as the quotient fits PIX_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= {1'b0, num[NUM_W-1:PIX_W]};
      nb_r  <= num[PIX_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nb_r  <= {nb_r[PIX_W-2:0], geq};
    end else if (rnd_r) begin
      nb_r <= nb_r + PIX_W'(round_up);
    end
  end

  assign done = done_r;
  assign quot = nb_r;

endmodule

`default_nettype wire

FILE: hw/rtl/heightmap_range_normalizer_unit.sv
// Top level of the heightmap range normaliser: measure pass statistics and map pass scaling.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+-------------------
//   input    | in_operation, in_elevation, in_pass_start      | in_valid/in_ready
//   result   | out_pixel                                      | out_valid/out_ready
//   config   | cfg_index, cfg_wr_data                         | cfg_wr_en
//
// One item at a time; the 24-step serial multiplier sets most of the time. A measure item
// runs through ST_MUL and ST_UPD, which updates the statistics, and the next item is taken
// back in ST_IDLE. A map item that needs the 16-step divider runs through ST_MUL, ST_RANGE,
// ST_CLASS, ST_SCALE, ST_DIV and ST_EMIT; a flat or clamped pixel skips ST_SCALE and ST_DIV.
// Reset is synchronous and clears configuration, statistics and raster position.
// The output register frees the input side: a new item is taken while a pixel waits,
// and a finished pixel waits in its final state only while the output is still full.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_range_normalizer_unit
  import hrn_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic [ELEV_W-1:0]     in_elevation,
  input  wire logic                  in_pass_start,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_pixel,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int CMP_W = (COL_W + 1 > ROW_LEN_W) ? COL_W + 1 : ROW_LEN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_CLASS = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  // Configuration registers
  logic                 depth_mode_r;
  logic [DS_W-1:0]      downscale_r;
  logic [ZS_W-1:0]      z_scale_r;
  logic [ELEV_W-1:0]    nodata_value_r;
  logic [ROW_LEN_W-1:0] row_length_r;

  // Statistics and position
  z_t               grid_min_r;
  logic             grid_seen_r;
  z_t               frame_min_r;
  z_t               frame_max_r;
  logic [COL_W-1:0] col_r;
  logic [DS_W-1:0]  col_phase_r;
  logic [DS_W-1:0]  row_phase_r;

  // Item in flight
  logic [2:0]         state_r;
  logic               op_r;
  logic               nodata_r;
  logic               grid_hit_r;
  logic signed [Z_W:0] range_r;
  logic signed [Z_W:0] diff_r;
  logic               ge_max_r;
  logic [PIX_W-1:0]   pix_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r;

  logic             accept;
  logic             mul_done;
  z_t               z_mul;
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_quot;
  logic [NUM_W-1:0] div_num;

  logic [COL_W-1:0] col0;
  logic [DS_W-1:0]  cph0;
  logic [DS_W-1:0]  rph0;
  logic [DS_W-1:0]  ds_eff;
  logic [CMP_W-1:0] len_eff;
  logic             row_wrap;
  logic [COL_W-1:0] col_nxt;
  logic [DS_W-1:0]  cph_nxt;
  logic [DS_W-1:0]  rph_nxt;
  logic [DS_W:0]    cph_inc;
  logic [DS_W:0]    rph_inc;

  z_t               z_sel;
  logic [Z_W-1:0]   diff_u;
  logic [PIX_W-1:0] scale_s;
  logic             flat;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // Raster position: clear on pass start, then advance by one sample
  always_comb begin
    col0 = in_pass_start ? '0 : col_r;
    cph0 = in_pass_start ? '0 : col_phase_r;
    rph0 = in_pass_start ? '0 : row_phase_r;
    ds_eff = (downscale_r == '0) ? DS_W'(1) : downscale_r;
    if (row_length_r == '0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(row_length_r) > CMP_W'(MAX_ROW_LENGTH)) begin
      len_eff = CMP_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = CMP_W'(row_length_r);
    end
    row_wrap = ((CMP_W'(col0) + CMP_W'(1)) >= len_eff);
    cph_inc  = {1'b0, cph0} + (DS_W+1)'(1);
    rph_inc  = {1'b0, rph0} + (DS_W+1)'(1);
    if (row_wrap) begin
      col_nxt = '0;
      cph_nxt = '0;
      rph_nxt = (rph_inc >= {1'b0, ds_eff}) ? '0 : rph_inc[DS_W-1:0];
    end else begin
      col_nxt = col0 + COL_W'(1);
      cph_nxt = (cph_inc >= {1'b0, ds_eff}) ? '0 : cph_inc[DS_W-1:0];
      rph_nxt = rph0;
    end
  end

  // Map pass operands
  always_comb begin
    if (nodata_r) begin
      z_sel = grid_seen_r ? grid_min_r : frame_min_r;
    end else begin
      z_sel = z_mul;
    end
    scale_s = depth_mode_r ? SCALE_16 : SCALE_8;
    flat    = (range_r <= (Z_W+1)'(FLAT_LIMIT));
    diff_u  = diff_r[Z_W-1:0];
    if (depth_mode_r) begin
      div_num = {diff_u, {SHIFT_16{1'b0}}} - {{PIX_W{1'b0}}, diff_u};
    end else begin
      div_num = {{(PIX_W-SHIFT_8){1'b0}}, diff_u, {SHIFT_8{1'b0}}}
                - {{PIX_W{1'b0}}, diff_u};
    end
    div_start = (state_r == ST_SCALE);
  end

  hrn_serial_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .mcand   (in_elevation),
    .mplier  (z_scale_r),
    .done    (mul_done),
    .product (z_mul)
  );

  hrn_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (range_r[Z_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r   <= 1'b0;
      downscale_r    <= DOWNSCALE_RST;
      z_scale_r      <= Z_SCALE_RST;
      nodata_value_r <= NODATA_RST;
      row_length_r   <= ROW_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEPTH_MODE:   depth_mode_r   <= cfg_wr_data[0];
        CFG_DOWNSCALE:    downscale_r    <= cfg_wr_data[DS_W-1:0];
        CFG_Z_SCALE:      z_scale_r      <= cfg_wr_data[ZS_W-1:0];
        CFG_NODATA_VALUE: nodata_value_r <= cfg_wr_data[ELEV_W-1:0];
        CFG_ROW_LENGTH:   row_length_r   <= cfg_wr_data[ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, statistics and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      grid_min_r  <= Z_POS_LIMIT;
      grid_seen_r <= 1'b0;
      frame_min_r <= Z_POS_LIMIT;
      frame_max_r <= Z_NEG_LIMIT;
      col_r       <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
    end else begin
      // load a finished pixel, or drop the held one once taken
      if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            col_r       <= col_nxt;
            col_phase_r <= cph_nxt;
            row_phase_r <= rph_nxt;
            if (in_pass_start && !in_operation) begin
              grid_min_r  <= Z_POS_LIMIT;
              grid_seen_r <= 1'b0;
              frame_min_r <= Z_POS_LIMIT;
              frame_max_r <= Z_NEG_LIMIT;
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_r <= op_r ? ST_RANGE : ST_UPD;
          end
        end
        ST_UPD: begin
          // fold the sample into the frame and grid statistics
          if (!nodata_r) begin
            if (z_mul < frame_min_r) frame_min_r <= z_mul;
            if (z_mul > frame_max_r) frame_max_r <= z_mul;
            if (grid_hit_r) begin
              grid_seen_r <= 1'b1;
              if (z_mul < grid_min_r) grid_min_r <= z_mul;
            end
          end
          state_r <= ST_IDLE;
        end
        ST_RANGE: begin
          state_r <= ST_CLASS;
        end
        ST_CLASS: begin
          state_r <= (flat || (diff_r <= (Z_W+1)'(0)) || ge_max_r) ? ST_EMIT : ST_SCALE;
        end
        ST_SCALE: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_operation;
      nodata_r   <= (in_elevation == nodata_value_r);
      grid_hit_r <= (cph0 == '0) && (rph0 == '0);
    end
    if (state_r == ST_RANGE) begin
      range_r  <= {frame_max_r[Z_W-1], frame_max_r} - {frame_min_r[Z_W-1], frame_min_r};
      diff_r   <= {z_sel[Z_W-1], z_sel} - {frame_min_r[Z_W-1], frame_min_r};
      ge_max_r <= (z_sel >= frame_max_r);
    end
    if (state_r == ST_CLASS) begin
      if (flat) begin
        pix_r <= depth_mode_r ? FLAT_MID_16 : '0;
      end else if (diff_r <= (Z_W+1)'(0)) begin
        pix_r <= '0;
      end else begin
        pix_r <= scale_s;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      pix_r <= (div_quot > scale_s) ? scale_s : div_quot;
    end
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_pixel_r <= pix_r;
    end
  end

endmodule

`default_nettype wire
